// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the checker files of this block.
// Depends on nothing; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset
`define EFI_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset
`define EFI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== hw/rtl/efi_pkg.sv =====
// Shared types and constants of the escape-time fractal iterator.
// No dependencies; every module of the block imports it.
package efi_pkg;

    // Default datapath format: signed Q4.28
    localparam int DEFAULT_COORD_BITS = 32;
    localparam int DEFAULT_FRAC_BITS  = 28;

    // Field widths fixed by the register map
    localparam int VAR_W   = 4;
    localparam int LIMIT_W = 16;
    localparam int BAIL_W  = 64;

    // Configuration port
    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_VARIANT  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LIMIT    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BAILOUT  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_SEED_RE  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SEED_IM  = 3'd4;

    // Reset values
    localparam logic [LIMIT_W-1:0] LIMIT_RESET   = 16'd256;
    localparam logic [BAIL_W-1:0]  BAILOUT_RESET = 64'h0400_0000_0000_0000;

    // Depth of the queue between front and engine
    localparam int QUEUE_DEPTH = 2;

    // Map selection
    typedef enum logic [VAR_W-1:0] {
        V_MANDEL  = 4'd0,
        V_JULIA   = 4'd1,
        V_BURN    = 4'd2,
        V_TRICORN = 4'd3,
        V_BUFFALO = 4'd4,
        V_CELTIC  = 4'd5,
        V_PERP    = 4'd6,
        V_Z8      = 4'd7,
        V_ALPHA   = 4'd8,
        V_BARN_J  = 4'd9,
        V_BARN_M  = 4'd10,
        V_PHOENIX = 4'd11
    } efi_variant_t;

    // Engine sequencer states
    typedef enum logic [2:0] {
        E_IDLE,
        E_CMUL,
        E_UPD,
        E_PHX,
        E_BAIL,
        E_DONE
    } efi_state_t;

    // Iteration controls handed from the register file to the engine
    typedef struct packed {
        logic [LIMIT_W-1:0] limit;
        logic [BAIL_W-1:0]  bailout;
    } efi_cfg_t;

endpackage

// ===== hw/rtl/efi_queue.sv =====
// Short register FIFO between the front stage and the iteration engine.
// Depends on efi_pkg for the default depth.
module efi_queue
    import efi_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [IW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [IW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Advance pointers with wrap and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming beat
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/efi_front.sv =====
// Front stage: accepts pixel beats, resolves the map and the start value.
// Depends on efi_pkg; feeds efi_queue.
module efi_front
    import efi_pkg::*;
#(
    parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] c_re,
    input  logic signed [COORD_BITS-1:0] c_im,
    input  logic [VAR_W-1:0]             variant,
    input  logic signed [COORD_BITS-1:0] seed_re,
    input  logic signed [COORD_BITS-1:0] seed_im,
    output logic                         push_valid,
    input  logic                         push_ready,
    output logic [4*COORD_BITS+VAR_W-1:0] push_data
);

    localparam int EW = 4 * COORD_BITS + VAR_W;

    logic          fv_reg;
    logic [EW-1:0] fdata_reg, fdata_next;
    efi_variant_t  kind;
    logic          start_at_c;

    // Fold unused codes onto the plain map
    always_comb
    begin
        case (variant)
            V_MANDEL, V_JULIA, V_BURN, V_TRICORN, V_BUFFALO, V_CELTIC,
            V_PERP, V_Z8, V_ALPHA, V_BARN_J, V_BARN_M, V_PHOENIX:
                kind = efi_variant_t'(variant);
            default:
                kind = V_MANDEL;
        endcase
    end

    // Julia, Barnsley and Phoenix start from the pixel, the rest from the seed
    assign start_at_c = (kind == V_JULIA) || (kind == V_BARN_J) ||
                        (kind == V_BARN_M) || (kind == V_PHOENIX);

    assign fdata_next = start_at_c ? {kind, c_re, c_im, c_re, c_im}
                                   : {kind, c_re, c_im, seed_re, seed_im};

    assign in_ready   = !fv_reg || push_ready;
    assign push_valid = fv_reg;
    assign push_data  = fdata_reg;

    // Hold one classified beat until the queue takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            fv_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            fv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            fdata_reg <= fdata_next;
        end
    end

endmodule

// ===== hw/rtl/efi_engine.sv =====
// Iteration engine: runs the selected map on one shared fixed-point multiplier,
// tests the escape radius and drives the result register. Depends on efi_pkg.
module efi_engine
    import efi_pkg::*;
#(
    parameter int COORD_BITS = DEFAULT_COORD_BITS,
    parameter int FRAC_BITS  = DEFAULT_FRAC_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [4*COORD_BITS+VAR_W-1:0] q_data,
    input  efi_cfg_t                      cfg,
    input  logic signed [COORD_BITS-1:0]  seed_re,
    input  logic signed [COORD_BITS-1:0]  seed_im,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [LIMIT_W-1:0]            iteration_count,
    output logic signed [COORD_BITS-1:0]  final_re,
    output logic signed [COORD_BITS-1:0]  final_im
);

    localparam int W   = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int PW  = 2 * W;
    localparam int QW  = PW + 1;
    localparam int SW  = PW + 1;
    localparam int AW  = SW + 56;
    localparam int SHR = (2 * F >= 56) ? 2 * F - 56 : 0;
    localparam int SHL = (2 * F < 56) ? 56 - 2 * F : 0;

    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
    localparam logic [QW-1:0] LIM_POS = (QW'(1) << (W - 1)) - QW'(1);
    localparam logic [QW-1:0] LIM_NEG = QW'(1) << (W - 1);

    // 1.0, P1 = 0.56667 rounded to nearest, P2 = -0.5; each saturated
    localparam logic signed [W-1:0] ONE = (F <= W - 2) ? (W'(1) << F) : MAXV;
    localparam logic [65:0] P1_RAW =
        (66'd10453216464248991614 + (66'd1 << (63 - F))) >> (64 - F);
    localparam logic signed [W-1:0] P1 =
        (P1_RAW > 66'(LIM_POS)) ? MAXV : W'(P1_RAW);
    localparam logic signed [W-1:0] P2 =
        (F <= W) ? (W'(0) - (W'(1) << (F - 1))) : MINV;

    function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        logic signed [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1])
        begin
            sat_add = s[W] ? MINV : MAXV;
        end
        else
        begin
            sat_add = s[W-1:0];
        end
    endfunction

    function automatic logic signed [W-1:0] sat_neg(input logic signed [W-1:0] a);
        sat_neg = (a == MINV) ? MAXV : (W'(0) - a);
    endfunction

    function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                    input logic signed [W-1:0] b);
        sat_sub = sat_add(a, sat_neg(b));
    endfunction

    function automatic logic signed [W-1:0] sat_abs(input logic signed [W-1:0] a);
        sat_abs = a[W-1] ? sat_neg(a) : a;
    endfunction

    function automatic logic [W-1:0] mag(input logic signed [W-1:0] a);
        mag = a[W-1] ? (W'(0) - a) : a;
    endfunction

    efi_state_t state_reg, state_next;
    logic [2:0] k_reg;
    logic [1:0] pass_reg;
    efi_variant_t var_reg;

    logic signed [W-1:0] c_re_reg, c_im_reg;
    logic signed [W-1:0] z_re_reg, z_im_reg;
    logic signed [W-1:0] y_re_reg, y_im_reg;
    logic signed [W-1:0] t_re_reg, t_im_reg;
    logic signed [W-1:0] s_re_reg, s_im_reg;
    logic signed [W-1:0] f0_reg, r_reg;
    logic [PW-1:0]       prod_reg, sq_reg;
    logic                neg_reg;
    logic [LIMIT_W-1:0]  cnt_reg;

    logic                out_valid_reg;
    logic [LIMIT_W-1:0]  out_count_reg;
    logic signed [W-1:0] out_re_reg, out_im_reg;

    logic signed [W-1:0] ar, ai, br, bi;
    logic signed [W-1:0] op_a, op_b;
    logic signed [W-1:0] fm;
    logic signed [W-1:0] new_re, new_im;
    logic [1:0]          last_pass;
    logic                cmul_end, below, keep_going, out_free;

    logic [QW-1:0] q_w, rem_mask;
    logic [AW-1:0] sq_sum, sq_al;

    // Floor and saturate the registered exact product
    always_comb
    begin
        q_w      = {1'b0, prod_reg} >> F;
        rem_mask = (QW'(1) << F) - QW'(1);
        if (neg_reg && (({1'b0, prod_reg} & rem_mask) != '0))
        begin
            q_w = q_w + QW'(1);
        end
        if (q_w > (neg_reg ? LIM_NEG : LIM_POS))
        begin
            fm = neg_reg ? MINV : MAXV;
        end
        else
        begin
            fm = neg_reg ? (W'(0) - q_w[W-1:0]) : q_w[W-1:0];
        end
    end

    // Escape test on x^2 + y^2, aligned to 56 fraction bits
    always_comb
    begin
        sq_sum = AW'(sq_reg) + AW'(prod_reg);
        sq_al  = (sq_sum >> SHR) << SHL;
        below  = (sq_al[AW-1:BAIL_W] == '0) && (sq_al[BAIL_W-1:0] < cfg.bailout);
    end

    assign keep_going = (cnt_reg < cfg.limit) && below;

    // Complex multiply operands per map and pass
    always_comb
    begin
        ar = z_re_reg;
        ai = z_im_reg;
        br = z_re_reg;
        bi = z_im_reg;
        if (pass_reg == 2'd0)
        begin
            case (var_reg)
                V_BURN:
                begin
                    ar = sat_abs(z_re_reg);
                    ai = sat_abs(z_im_reg);
                end
                V_TRICORN: ai = sat_neg(z_im_reg);
                V_PERP:    ai = sat_neg(sat_abs(z_im_reg));
                V_BARN_J, V_BARN_M:
                begin
                    ar = z_re_reg[W-1] ? sat_add(z_re_reg, ONE) : sat_sub(z_re_reg, ONE);
                end
                default: ar = z_re_reg;
            endcase
            if (var_reg == V_BARN_J)
            begin
                br = seed_re;
                bi = seed_im;
            end
            else if (var_reg == V_BARN_M)
            begin
                br = c_re_reg;
                bi = c_im_reg;
            end
            else
            begin
                br = ar;
                bi = ai;
            end
        end
        else if (var_reg == V_ALPHA)
        begin
            ar = sat_add(s_re_reg, c_re_reg);
            ai = sat_add(s_im_reg, c_im_reg);
            br = ar;
            bi = ai;
        end
        else
        begin
            ar = t_re_reg;
            ai = t_im_reg;
            br = t_re_reg;
            bi = t_im_reg;
        end
    end

    // Extra squarings for the octic and alpha maps
    always_comb
    begin
        case (var_reg)
            V_Z8:    last_pass = 2'd2;
            V_ALPHA: last_pass = 2'd1;
            default: last_pass = 2'd0;
        endcase
    end

    assign cmul_end = (k_reg == 3'd4) && (pass_reg == last_pass);
    assign out_free = !out_valid_reg || out_ready;

    // Combine the product with c, the seed or the first-pass square, or pass it through
    always_comb
    begin
        case (var_reg)
            V_JULIA:
            begin
                new_re = sat_add(t_re_reg, seed_re);
                new_im = sat_add(t_im_reg, seed_im);
            end
            V_BUFFALO:
            begin
                new_re = sat_add(sat_abs(t_re_reg), c_re_reg);
                new_im = sat_add(sat_abs(t_im_reg), c_im_reg);
            end
            V_CELTIC:
            begin
                new_re = sat_add(sat_abs(t_re_reg), c_re_reg);
                new_im = sat_add(t_im_reg, c_im_reg);
            end
            V_ALPHA:
            begin
                new_re = sat_add(sat_add(s_re_reg, t_re_reg), c_re_reg);
                new_im = sat_add(sat_add(s_im_reg, t_im_reg), c_im_reg);
            end
            V_BARN_J, V_BARN_M:
            begin
                new_re = t_re_reg;
                new_im = t_im_reg;
            end
            default:
            begin
                new_re = sat_add(t_re_reg, c_re_reg);
                new_im = sat_add(t_im_reg, c_im_reg);
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            E_IDLE: if (q_valid) state_next = E_CMUL;
            E_CMUL:
            begin
                if (cmul_end)
                begin
                    state_next = (var_reg == V_PHOENIX) ? E_PHX : E_UPD;
                end
            end
            E_UPD:  state_next = E_BAIL;
            E_PHX:  if (k_reg == 3'd2) state_next = E_BAIL;
            E_BAIL:
            begin
                if (k_reg == 3'd2)
                begin
                    state_next = keep_going ? E_CMUL : E_DONE;
                end
            end
            E_DONE: if (out_free) state_next = E_IDLE;
            default: state_next = E_IDLE;
        endcase
    end

    // Multiplier operands and queue pop
    always_comb
    begin
        op_a    = ar;
        op_b    = br;
        q_ready = 1'b0;
        case (state_reg)
            E_IDLE: q_ready = 1'b1;
            E_CMUL:
            begin
                case (k_reg)
                    3'd0:
                    begin
                        op_a = ar;
                        op_b = br;
                    end
                    3'd1:
                    begin
                        op_a = ai;
                        op_b = bi;
                    end
                    3'd2:
                    begin
                        op_a = ar;
                        op_b = bi;
                    end
                    default:
                    begin
                        op_a = ai;
                        op_b = br;
                    end
                endcase
            end
            E_PHX:
            begin
                op_a = (k_reg == 3'd0) ? y_re_reg : y_im_reg;
                op_b = P2;
            end
            E_BAIL:
            begin
                op_a = (k_reg == 3'd0) ? z_re_reg : z_im_reg;
                op_b = op_a;
            end
            default:
            begin
                op_a = ar;
                op_b = br;
            end
        endcase
    end

    // Sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= E_IDLE;
            k_reg         <= '0;
            pass_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
            begin
                k_reg    <= '0;
                pass_reg <= '0;
            end
            else if (state_reg == E_CMUL && k_reg == 3'd4)
            begin
                k_reg    <= '0;
                pass_reg <= pass_reg + 1'b1;
            end
            else
            begin
                k_reg <= k_reg + 1'b1;
            end
            if (state_reg == E_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(mag(op_a)) * PW'(mag(op_b));
        neg_reg  <= op_a[W-1] ^ op_b[W-1];
        case (state_reg)
            E_IDLE:
            begin
                if (q_valid)
                begin
                    var_reg  <= efi_variant_t'(q_data[4*W +: VAR_W]);
                    c_re_reg <= q_data[3*W +: W];
                    c_im_reg <= q_data[2*W +: W];
                    z_re_reg <= q_data[W +: W];
                    z_im_reg <= q_data[0 +: W];
                    y_re_reg <= '0;
                    y_im_reg <= '0;
                    cnt_reg  <= '0;
                end
            end
            E_CMUL:
            begin
                case (k_reg)
                    3'd1, 3'd3: f0_reg <= fm;
                    3'd2:       r_reg  <= sat_sub(f0_reg, fm);
                    3'd4:
                    begin
                        t_re_reg <= r_reg;
                        t_im_reg <= sat_add(f0_reg, fm);
                        if (pass_reg == 2'd0)
                        begin
                            s_re_reg <= r_reg;
                            s_im_reg <= sat_add(f0_reg, fm);
                        end
                    end
                    default: f0_reg <= f0_reg;
                endcase
            end
            E_UPD:
            begin
                z_re_reg <= new_re;
                z_im_reg <= new_im;
                cnt_reg  <= cnt_reg + 1'b1;
            end
            E_PHX:
            begin
                if (k_reg == 3'd1)
                begin
                    f0_reg <= fm;
                end
                else if (k_reg == 3'd2)
                begin
                    z_re_reg <= sat_add(sat_add(t_re_reg, P1), f0_reg);
                    z_im_reg <= sat_add(t_im_reg, fm);
                    y_re_reg <= z_re_reg;
                    y_im_reg <= z_im_reg;
                    cnt_reg  <= cnt_reg + 1'b1;
                end
            end
            E_BAIL:
            begin
                if (k_reg == 3'd1)
                begin
                    sq_reg <= prod_reg;
                end
            end
            E_DONE:
            begin
                if (out_free)
                begin
                    out_count_reg <= cnt_reg;
                    out_re_reg    <= z_re_reg;
                    out_im_reg    <= z_im_reg;
                end
            end
            default: sq_reg <= sq_reg;
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign iteration_count = out_count_reg;
    assign final_re        = out_re_reg;
    assign final_im        = out_im_reg;

endmodule

// ===== hw/rtl/escape_time_fractal_iterator.sv =====
// Top level of the escape-time fractal iterator: register file, front stage,
// queue and iteration engine. Depends on efi_pkg, efi_front, efi_queue, efi_engine.
//
// Usage:
//   Input channel (in_valid/in_ready, c_re, c_im) takes one pixel coordinate per
//   beat; output channel (out_valid/out_ready, iteration_count, final_re,
//   final_im) returns one result beat per pixel, in order.
//   Registers sit on the APB port at byte address 8*i: variant, iteration_limit,
//   bailout_sq, seed_re, seed_im. pready is always high; write only while idle.
//   The path from input beat to result beat runs through the front stage, the
//   queue pop, the iteration steps and the result load. One pixel is iterated at
//   a time on the single shared multiplier (one product per cycle, four per complex
//   product and two per escape test).
//   Three more pixels can wait in the front stage and queue while one iterates.
//   Reset clears all valids, empties the queue and loads the register defaults
//   (plain map, limit 256, bailout 4.0, seed 0).
//   A stalled receiver holds the result register; the engine finishes the next
//   pixel and waits, and the input side backs up once queue and front are full.
module escape_time_fractal_iterator
    import efi_pkg::*;
#(
    parameter int COORD_BITS = DEFAULT_COORD_BITS,
    parameter int FRAC_BITS  = DEFAULT_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [COORD_BITS-1:0] c_re,
    input  logic signed [COORD_BITS-1:0] c_im,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [LIMIT_W-1:0]           iteration_count,
    output logic signed [COORD_BITS-1:0] final_re,
    output logic signed [COORD_BITS-1:0] final_im,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [APB_ADDR_W-1:0]        paddr,
    input  logic [APB_DATA_W-1:0]        pwdata,
    output logic [APB_DATA_W-1:0]        prdata,
    output logic                         pready
);

    localparam int EW = 4 * COORD_BITS + VAR_W;

    logic [VAR_W-1:0]             variant_reg;
    logic [LIMIT_W-1:0]           limit_reg;
    logic [BAIL_W-1:0]            bailout_reg;
    logic signed [COORD_BITS-1:0] seed_re_reg, seed_im_reg;
    logic [REG_IDX_W-1:0]         reg_idx;
    logic                         wr_en;
    efi_cfg_t                     cfg;

    logic          f_valid, f_ready;
    logic [EW-1:0] f_data;
    logic          e_valid, e_ready;
    logic [EW-1:0] e_data;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:3];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            variant_reg <= V_MANDEL;
            limit_reg   <= LIMIT_RESET;
            bailout_reg <= BAILOUT_RESET;
            seed_re_reg <= '0;
            seed_im_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_VARIANT: variant_reg <= pwdata[VAR_W-1:0];
                REG_LIMIT:   limit_reg   <= pwdata[LIMIT_W-1:0];
                REG_BAILOUT: bailout_reg <= pwdata[BAIL_W-1:0];
                REG_SEED_RE: seed_re_reg <= pwdata[COORD_BITS-1:0];
                REG_SEED_IM: seed_im_reg <= pwdata[COORD_BITS-1:0];
                default:     variant_reg <= variant_reg;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        case (reg_idx)
            REG_VARIANT: prdata = APB_DATA_W'(variant_reg);
            REG_LIMIT:   prdata = APB_DATA_W'(limit_reg);
            REG_BAILOUT: prdata = APB_DATA_W'(bailout_reg);
            REG_SEED_RE: prdata = APB_DATA_W'($unsigned(seed_re_reg));
            REG_SEED_IM: prdata = APB_DATA_W'($unsigned(seed_im_reg));
            default:     prdata = '0;
        endcase
    end

    assign cfg.limit   = limit_reg;
    assign cfg.bailout = bailout_reg;

    efi_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .c_re       (c_re),
        .c_im       (c_im),
        .variant    (variant_reg),
        .seed_re    (seed_re_reg),
        .seed_im    (seed_im_reg),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data)
    );

    efi_queue #(
        .WIDTH (EW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_data  (f_data),
        .pop_valid  (e_valid),
        .pop_ready  (e_ready),
        .pop_data   (e_data)
    );

    efi_engine #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_engine (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (e_valid),
        .q_ready         (e_ready),
        .q_data          (e_data),
        .cfg             (cfg),
        .seed_re         (seed_re_reg),
        .seed_im         (seed_im_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .iteration_count (iteration_count),
        .final_re        (final_re),
        .final_im        (final_im)
    );

endmodule

// ===== hw/rtl/efi_checker.sv =====
// Port-level checks of the escape-time fractal iterator, bound to the top level.
// Depends on efi_pkg and assert_macros.svh.
`include "assert_macros.svh"

module efi_checker
    import efi_pkg::*;
#(
    parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [LIMIT_W-1:0]           iteration_count,
    input logic signed [COORD_BITS-1:0] final_re,
    input logic signed [COORD_BITS-1:0] final_im,
    input logic                         pready
);

    // A stalled result beat holds its payload
    `EFI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(iteration_count) && $stable(final_re) && $stable(final_im))

    // Every pixel runs at least one step
    `EFI_ASSERT_IMPLY(a_count_nonzero, clk, rst_n, out_valid, iteration_count != '0)

    // Register port never inserts wait states
    `EFI_ASSERT_IMPLY(a_pready_high, clk, rst_n, 1'b1, pready)

endmodule

bind escape_time_fractal_iterator efi_checker #(
    .COORD_BITS (COORD_BITS)
) u_efi_checker (.*);
